FILE: rtl/core/mbet_pkg.sv
// Shared types and constants for the escape-time evaluator.
// Depends on nothing; every other file in rtl/core imports it.
package mbet_pkg;

  localparam int DATA_W        = 32;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int SUM_W         = PROD_W + 1;
  localparam int CNT_W         = 16;
  localparam int PIX_W         = 12;
  localparam int DIM_W         = 13;
  localparam int SCALE_W       = 31;
  localparam int CLAMP_W       = 17;
  localparam int TWICE_W       = CLAMP_W + 1;
  localparam int CFG_IDX_W     = 3;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 40;
  localparam int MAX_DIM_DEF   = 4096;
  localparam int FRAC_BITS_DEF = 28;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE    = 3'd0,
    REG_OFFSET_X = 3'd1,
    REG_OFFSET_Y = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4,
    REG_LIMIT    = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_MAP_X,
    MUL_MAP_Y,
    MUL_XX,
    MUL_YY,
    MUL_XY
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_X,
    S_MAP_Y,
    S_INIT,
    S_SQ_X,
    S_SQ_Y,
    S_XY,
    S_UPD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [SCALE_W-1:0]       scale;
    logic signed [DATA_W-1:0] offset_x;
    logic signed [DATA_W-1:0] offset_y;
    logic [DIM_W-1:0]         width;
    logic [DIM_W-1:0]         height;
    logic [CNT_W-1:0]         limit;
  } cfg_t;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     load_in;
    logic     cap_x0;
    logic     init;
    logic     cap_xx;
    logic     cap_yy;
    logic     upd;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic at_limit;
    logic escape;
  } stat_t;

endpackage

FILE: rtl/core/mbet_ctrl.sv
// Sequencer for the escape-time evaluator: steps the shared multiplier
// through mapping and iteration and owns the handshakes. Uses mbet_pkg.
module mbet_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  mbet_pkg::stat_t stat_i,
  output mbet_pkg::cmd_t  cmd_o
);
  import mbet_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_XX;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MAP_X;
        end
      end
      S_MAP_X: begin
        cmd_o.mul_sel = MUL_MAP_X;
        state_d       = S_MAP_Y;
      end
      S_MAP_Y: begin
        cmd_o.mul_sel = MUL_MAP_Y;
        cmd_o.cap_x0  = 1'b1;
        state_d       = S_INIT;
      end
      // first iteration from zero lands on c itself
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = stat_i.at_limit ? S_DONE : S_SQ_X;
      end
      S_SQ_X: begin
        cmd_o.mul_sel = MUL_XX;
        state_d       = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd_o.mul_sel = MUL_YY;
        cmd_o.cap_xx  = 1'b1;
        state_d       = S_XY;
      end
      S_XY: begin
        cmd_o.mul_sel = MUL_XY;
        cmd_o.cap_yy  = 1'b1;
        state_d       = stat_i.escape ? S_DONE : S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = stat_i.at_limit ? S_DONE : S_SQ_X;
      end
      // hold until the output register is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/mbet_dpath.sv
// Datapath of the escape-time evaluator: one shared 32x32 signed multiplier,
// iteration registers, count and output register. Uses mbet_pkg.
module mbet_dpath #(
  parameter int MAX_DIM   = mbet_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mbet_pkg::cfg_t              cfg_i,
  input  mbet_pkg::cmd_t              cmd_i,
  output mbet_pkg::stat_t             stat_o,
  input  logic [mbet_pkg::PIX_W-1:0]  pixel_x_i,
  input  logic [mbet_pkg::PIX_W-1:0]  pixel_y_i,
  output logic [mbet_pkg::CNT_W-1:0]  count_o,
  output logic [mbet_pkg::PIX_W-1:0]  echo_x_o,
  output logic [mbet_pkg::PIX_W-1:0]  echo_y_o
);
  import mbet_pkg::*;

  localparam int SH_W  = PROD_W - FRAC_BITS;
  localparam int CMP_W = (SH_W + 1 > FRAC_BITS + 4) ? SH_W + 1 : FRAC_BITS + 4;
  localparam logic signed [CMP_W-1:0] FOUR = CMP_W'(4) <<< FRAC_BITS;
  localparam logic [CLAMP_W-1:0] DIM_LIM = CLAMP_W'(MAX_DIM);

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DATA_W:0] top;
    top = v[SUM_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  logic [PIX_W-1:0]         px_q, py_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [DATA_W-1:0] x0_q, y0_q, x_q, y_q;
  logic signed [SH_W-1:0]   xx_q, yy_q;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         out_cnt_q;
  logic [PIX_W-1:0]         out_x_q, out_y_q;

  logic [CLAMP_W-1:0]       width_c, height_c;
  logic signed [TWICE_W-1:0] twice_x, twice_y;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] map_v;
  logic signed [SUM_W-1:0]  map_x_sum, map_y_sum;
  logic signed [DATA_W-1:0] x0_new, y0_new;
  logic signed [SH_W-1:0]   prod_sh;
  logic signed [SUM_W-1:0]  x_sum, y_sum;
  logic signed [CMP_W-1:0]  esc_sum;
  logic [CNT_W-1:0]         lim_eff;

  // clamp the area size, then (2*pos - size) for the pixel offset
  assign width_c  = ({4'd0, cfg_i.width}  > DIM_LIM) ? DIM_LIM : {4'd0, cfg_i.width};
  assign height_c = ({4'd0, cfg_i.height} > DIM_LIM) ? DIM_LIM : {4'd0, cfg_i.height};
  assign twice_x  = $signed({5'd0, px_q, 1'b0}) - $signed({1'b0, width_c});
  assign twice_y  = $signed({5'd0, py_q, 1'b0}) - $signed({1'b0, height_c});

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_MAP_X: begin
        mul_a = DATA_W'(twice_x);
        mul_b = $signed({1'b0, cfg_i.scale});
      end
      MUL_MAP_Y: begin
        mul_a = DATA_W'(twice_y);
        mul_b = $signed({1'b0, cfg_i.scale});
      end
      MUL_XX: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      MUL_YY: begin
        mul_a = y_q;
        mul_b = y_q;
      end
      MUL_XY: begin
        mul_a = x_q;
        mul_b = y_q;
      end
      default: begin
        mul_a = x_q;
        mul_b = y_q;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // mapping: halve with floor, then apply the offsets
  assign map_v     = prod_q >>> 1;
  assign map_x_sum = SUM_W'(map_v) + SUM_W'(cfg_i.offset_x);
  assign map_y_sum = SUM_W'(map_v) - SUM_W'(cfg_i.offset_y);
  assign x0_new    = sat32(map_x_sum);
  assign y0_new    = sat32(map_y_sum);

  // iteration: floor shift of the registered product
  assign prod_sh = prod_q[PROD_W-1:FRAC_BITS];
  assign x_sum   = SUM_W'(xx_q) - SUM_W'(yy_q) + SUM_W'(x0_q);
  assign y_sum   = (SUM_W'(prod_sh) <<< 1) + SUM_W'(y0_q);
  assign esc_sum = CMP_W'(xx_q) + CMP_W'(prod_sh);

  assign lim_eff = (cfg_i.limit == '0) ? CNT_W'(1) : cfg_i.limit;

  assign stat_o.escape   = (esc_sum >= FOUR);
  assign stat_o.at_limit = ({1'b0, count_q} + (CNT_W + 1)'(1)) >= {1'b0, lim_eff};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load_in) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    if (cmd_i.cap_x0) begin
      x0_q <= x0_new;
    end
    if (cmd_i.init) begin
      y0_q <= y0_new;
      x_q  <= x0_q;
      y_q  <= y0_new;
    end
    if (cmd_i.cap_xx) begin
      xx_q <= prod_sh;
    end
    if (cmd_i.cap_yy) begin
      yy_q <= prod_sh;
    end
    if (cmd_i.upd) begin
      x_q <= sat32(x_sum);
      y_q <= sat32(y_sum);
    end
    if (cmd_i.load_out) begin
      out_cnt_q <= count_q;
      out_x_q   <= px_q;
      out_y_q   <= py_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load_in) begin
      count_q <= '0;
    end else if (cmd_i.init || cmd_i.upd) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  assign count_o  = out_cnt_q;
  assign echo_x_o = out_x_q;
  assign echo_y_o = out_y_q;

endmodule

FILE: rtl/core/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time evaluator: configuration registers,
// sequencer (mbet_ctrl) and datapath (mbet_dpath). Uses mbet_pkg.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+---------------------------
//   s_axis   | in        | s_axis_tvalid/s_axis_tready | pixel_x, pixel_y
//   m_axis   | out       | m_axis_tvalid/m_axis_tready | iteration_count, echo_x, echo_y
//   cfg      | in        | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// Mapping and each iteration share one 32x32 multiplier: mapping runs the x and y
// products, and each iteration runs x*x, y*y and x*y through it, with a registered
// product before each update.
// One pixel is in work at a time; a new one is taken while the last result
// waits in the output register, and the finished pixel holds until that register
// frees. Reset clears the registers to their defaults (iteration limit 1).
// Configuration writes are always taken.
module mandelbrot_escape_time #(
  parameter int MAX_DIM   = mbet_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [11:0] pixel_x, [23:12] pixel_y
  input  logic [mbet_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] iteration_count, [27:16] echo_x, [39:28] echo_y
  output logic [mbet_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mbet_pkg::DATA_W-1:0]       cfg_data_i
);
  import mbet_pkg::*;

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;

  logic [CNT_W-1:0] count;
  logic [PIX_W-1:0] echo_x, echo_y;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale    <= '0;
      cfg_q.offset_x <= '0;
      cfg_q.offset_y <= '0;
      cfg_q.width    <= '0;
      cfg_q.height   <= '0;
      cfg_q.limit    <= CNT_W'(1);
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SCALE:    cfg_q.scale    <= cfg_data_i[SCALE_W-1:0];
        REG_OFFSET_X: cfg_q.offset_x <= cfg_data_i;
        REG_OFFSET_Y: cfg_q.offset_y <= cfg_data_i;
        REG_WIDTH:    cfg_q.width    <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT:   cfg_q.height   <= cfg_data_i[DIM_W-1:0];
        REG_LIMIT:    cfg_q.limit    <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  mbet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mbet_dpath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .pixel_x_i (s_axis_tdata[PIX_W-1:0]),
    .pixel_y_i (s_axis_tdata[2*PIX_W-1:PIX_W]),
    .count_o   (count),
    .echo_x_o  (echo_x),
    .echo_y_o  (echo_y)
  );

  assign m_axis_tdata = {echo_y, echo_x, count};

  // a pixel transfer starts work, so no second one is taken right after
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a pixel is in work");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (count != '0))
    else $error("result with zero iterations");

  a_count_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (count <= cfg_q.limit || cfg_q.limit == '0))
    else $error("iteration count beyond the limit");

endmodule
